>>> sv/obb_sp_pkg.sv
// Shared types, widths and helpers for the oriented-box support point pipeline.
package obb_sp_pkg;

  // Field and datapath widths
  localparam int HALF_W   = 31;              // half-extent, unsigned Q15.16
  localparam int MAT_W    = 34;              // rotation matrix entry, Q.28
  localparam int TERM_W   = 66;              // entry * half-extent, Q.44
  localparam int SUM_W    = TERM_W + 1;      // three terms plus rounding
  localparam int PT_W     = SUM_W - 28;      // rotated corner, Q23.16 unsaturated
  localparam int DOT_W    = 72;              // exact corner . direction
  localparam int PH_W     = PT_W - 16 + 32;  // high part product
  localparam int PL_W     = 17 + 32;         // low part product
  localparam int N_CORNER = 8;

  localparam logic [HALF_W-1:0] HALF_RESET = 31'd65536;
  localparam logic signed [MAT_W-1:0] MAT_ONE = 34'sd268435456;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 67'sd134217728;

  // Corner signs as {z, y, x}, 1 = positive, in selection order
  localparam logic [2:0] CORNER_POS [N_CORNER] = '{
    3'b001, 3'b011, 3'b010, 3'b000, 3'b101, 3'b111, 3'b110, 3'b100
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_item_t;

  // One corner candidate in the selection tree
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
    logic signed [PT_W-1:0]  pz;
  } cand_t;

  // Earlier candidate wins unless the later one is strictly greater
  function automatic cand_t pick_cand(input cand_t a, input cand_t b);
    pick_cand = (b.dot > a.dot) ? b : a;
  endfunction

  // Corner plus center, clamped to signed 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [PT_W-1:0] p,
                                                 input logic signed [31:0] c);
    logic signed [PT_W:0] s;
    s = (PT_W+1)'(p) + (PT_W+1)'(c);
    if (s > (PT_W+1)'(64'sd2147483647)) begin
      sat_add = 32'sh7fffffff;
    end else if (s < -(PT_W+1)'(64'sd2147483648)) begin
      sat_add = 32'sh80000000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

>>> sv/obb_sp_matrix.sv
// Quaternion to rotation matrix, entries in Q.28, row-major.
module obb_sp_matrix (
  input  logic signed [15:0]                      rot_w,
  input  logic signed [15:0]                      rot_x,
  input  logic signed [15:0]                      rot_y,
  input  logic signed [15:0]                      rot_z,
  output logic signed [obb_sp_pkg::MAT_W-1:0]     mat [9]
);
  import obb_sp_pkg::*;

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  // Pairwise products of the quaternion parts
  assign xx = rot_x * rot_x;
  assign yy = rot_y * rot_y;
  assign zz = rot_z * rot_z;
  assign xy = rot_x * rot_y;
  assign xz = rot_x * rot_z;
  assign yz = rot_y * rot_z;
  assign wx = rot_w * rot_x;
  assign wy = rot_w * rot_y;
  assign wz = rot_w * rot_z;

  // Standard matrix form, no normalization
  always_comb begin
    mat[0] = MAT_ONE - ((MAT_W'(yy) + MAT_W'(zz)) <<< 1);
    mat[1] = (MAT_W'(xy) - MAT_W'(wz)) <<< 1;
    mat[2] = (MAT_W'(xz) + MAT_W'(wy)) <<< 1;
    mat[3] = (MAT_W'(xy) + MAT_W'(wz)) <<< 1;
    mat[4] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(zz)) <<< 1);
    mat[5] = (MAT_W'(yz) - MAT_W'(wx)) <<< 1;
    mat[6] = (MAT_W'(xz) - MAT_W'(wy)) <<< 1;
    mat[7] = (MAT_W'(yz) + MAT_W'(wx)) <<< 1;
    mat[8] = MAT_ONE - ((MAT_W'(xx) + MAT_W'(yy)) <<< 1);
  end

endmodule

>>> sv/obb_support_point.sv
// Oriented-box support point: ten-stage pipeline, one query per cycle while out_stall is low.
//
// Input channel in_valid/in_stall/in_data carries a query: direction, box
// center (Q16.16) and rotation quaternion (Q2.14). Output channel
// out_valid/out_stall/out_data returns the box corner farthest along the
// direction, center added and clamped to 32 bits. Ties go to the earliest
// corner in the fixed corner order.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the three half-extents;
// cfg_ready is always high. Write them only while the pipeline is empty.
// Throughput: one request per cycle while out_stall is low; the stages are
// matrix, extent products, term sum, corner rounding, dot partial products,
// dot sum, three compare levels and the output clamp.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// fill while the output is stalled; in_stall rises only when all stages hold
// a request. A stalled result holds its value.
// Reset empties the pipeline and sets every half-extent to 1.0.
module obb_support_point (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  obb_sp_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output obb_sp_pkg::out_item_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [30:0]            cfg_data
);
  import obb_sp_pkg::*;

  localparam int NS = 10;

  logic [HALF_W-1:0] half_r [3];
  logic [NS:1]       v_r, v_nxt;
  logic [NS+1:1]     rdy;

  logic signed [MAT_W-1:0]  mat [9];
  logic signed [MAT_W-1:0]  m_r [9];
  logic signed [31:0]       d_r [1:4][3];
  logic signed [31:0]       c_r [1:9][3];
  logic signed [MAT_W+15:0] lo_r [9];
  logic signed [MAT_W+16:0] hi_r [9];
  logic signed [TERM_W-1:0] t_r [9];
  logic signed [PT_W-1:0]   p_r [N_CORNER][3];
  logic signed [PT_W-1:0]   p5_r [N_CORNER][3];
  logic signed [PH_W-1:0]   ph_r [N_CORNER][3];
  logic signed [PL_W-1:0]   pl_r [N_CORNER][3];
  cand_t                    c6_r [N_CORNER];
  cand_t                    c7_r [4];
  cand_t                    c8_r [2];
  cand_t                    c9_r;
  out_item_t                out_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= HALF_RESET;
      half_r[1] <= HALF_RESET;
      half_r[2] <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_X: half_r[0] <= cfg_data;
        REG_HALF_Y: half_r[1] <= cfg_data;
        REG_HALF_Z: half_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage load enables: a stage moves when empty or its successor moves
  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt[1] = rdy[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NS; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[NS];
  assign out_data  = out_r;

  // Direction and center ride along with the request
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d_r[1][0] <= in_data.dir_x;
      d_r[1][1] <= in_data.dir_y;
      d_r[1][2] <= in_data.dir_z;
      c_r[1][0] <= in_data.center_x;
      c_r[1][1] <= in_data.center_y;
      c_r[1][2] <= in_data.center_z;
    end
    for (int k = 2; k <= 4; k++) begin
      if (rdy[k]) d_r[k] <= d_r[k-1];
    end
    for (int k = 2; k <= 9; k++) begin
      if (rdy[k]) c_r[k] <= c_r[k-1];
    end
  end

  // Stage 1: rotation matrix
  obb_sp_matrix u_matrix (
    .rot_w (in_data.rot_w),
    .rot_x (in_data.rot_x),
    .rot_y (in_data.rot_y),
    .rot_z (in_data.rot_z),
    .mat   (mat)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) m_r <= mat;
  end

  // Stage 2: entry times half-extent, split 16/15 bits
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 9; i++) begin
        lo_r[i] <= m_r[i] * $signed({1'b0, half_r[i%3][14:0]});
        hi_r[i] <= m_r[i] * $signed({1'b0, half_r[i%3][30:15]});
      end
    end
  end

  // Stage 3: full terms in Q.44
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 9; i++) begin
        t_r[i] <= (TERM_W'(hi_r[i]) <<< 15) + TERM_W'(lo_r[i]);
      end
    end
  end

  // Stage 4: signed sums per corner, round half up to Q23.16
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < N_CORNER; c++) begin
        for (int r = 0; r < 3; r++) begin
          logic signed [SUM_W-1:0] s;
          s = ROUND_HALF;
          for (int k = 0; k < 3; k++) begin
            if (CORNER_POS[c][k]) s = s + SUM_W'(t_r[r*3+k]);
            else                  s = s - SUM_W'(t_r[r*3+k]);
          end
          p_r[c][r] <= PT_W'(s >>> 28);
        end
      end
    end
  end

  // Stage 5: dot partial products, corner split at bit 16
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p5_r <= p_r;
      for (int c = 0; c < N_CORNER; c++) begin
        for (int r = 0; r < 3; r++) begin
          ph_r[c][r] <= $signed(p_r[c][r][PT_W-1:16]) * d_r[4][r];
          pl_r[c][r] <= $signed({1'b0, p_r[c][r][15:0]}) * d_r[4][r];
        end
      end
    end
  end

  // Stage 6: exact dot products
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < N_CORNER; c++) begin
        c6_r[c].dot <= ((DOT_W'(ph_r[c][0]) + DOT_W'(ph_r[c][1]) + DOT_W'(ph_r[c][2]))
                        <<< 16) + DOT_W'(pl_r[c][0]) + DOT_W'(pl_r[c][1])
                        + DOT_W'(pl_r[c][2]);
        c6_r[c].px  <= p5_r[c][0];
        c6_r[c].py  <= p5_r[c][1];
        c6_r[c].pz  <= p5_r[c][2];
      end
    end
  end

  // Stages 7-9: compare tree, lower index wins ties
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int i = 0; i < 4; i++) c7_r[i] <= pick_cand(c6_r[2*i], c6_r[2*i+1]);
    end
    if (rdy[8]) begin
      for (int i = 0; i < 2; i++) c8_r[i] <= pick_cand(c7_r[2*i], c7_r[2*i+1]);
    end
    if (rdy[9]) begin
      c9_r <= pick_cand(c8_r[0], c8_r[1]);
    end
  end

  // Stage 10: add center and clamp
  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      out_r.point_x <= sat_add(c9_r.px, c_r[9][0]);
      out_r.point_y <= sat_add(c9_r.py, c_r[9][1]);
      out_r.point_z <= sat_add(c9_r.pz, c_r[9][2]);
    end
  end

`ifndef ASSERT_OFF
  // An empty output stage never backs up the input
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with empty output stage");

  // A draining output never backs up the input
  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall) else $error("input stalled while output drains");

  // An accepted request occupies the first stage
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1]) else $error("accepted request lost");

  // A stalled result stays valid
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r)))
    else $error("stalled result dropped or changed");
`endif

endmodule

>>> tb/obb_support_checker.sv
// Checker for the oriented-box support point block: predicts each corner and compares results.
module obb_support_checker
  import obb_sp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [30:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [30:0] ext_x, ext_y, ext_z;
  out_item_t   corner_q[$];

  // Floor division by 2^k on a wide signed value
  function automatic logic signed [127:0] floor_div(input logic signed [127:0] v, input int k);
    floor_div = v >>> k;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) clamp32 = 32'sh7fffffff;
    else if (v < -128'sd2147483648) clamp32 = 32'sh80000000;
    else clamp32 = v[31:0];
  endfunction

  // Support corner of the box for one query
  function automatic out_item_t support_corner(input in_item_t q);
    logic signed [127:0] w, x, y, z, m[3][3], e[3], p[3], best_p[3], dotv, best_dot, acc, v;
    logic signed [127:0] dv[3];
    int sgn;
    out_item_t r;
    w = q.rot_w; x = q.rot_x; y = q.rot_y; z = q.rot_z;
    e[0] = {97'd0, ext_x}; e[1] = {97'd0, ext_y}; e[2] = {97'd0, ext_z};
    dv[0] = q.dir_x; dv[1] = q.dir_y; dv[2] = q.dir_z;
    m[0][0] = 128'sd268435456 - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = 128'sd268435456 - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = 128'sd268435456 - 2 * (x * x + y * y);
    best_dot = 0;
    for (int i = 0; i < N_CORNER; i++) begin
      for (int rr = 0; rr < 3; rr++) begin
        acc = 128'sd134217728;
        for (int k = 0; k < 3; k++) begin
          sgn = CORNER_POS[i][k] ? 1 : -1;
          v = (sgn > 0) ? e[k] : -e[k];
          acc += m[rr][k] * v;
        end
        p[rr] = floor_div(acc, 28);
      end
      dotv = p[0] * dv[0] + p[1] * dv[1] + p[2] * dv[2];
      if (i == 0 || dotv > best_dot) begin
        best_dot = dotv;
        best_p = p;
      end
    end
    r.point_x = clamp32(best_p[0] + 128'(q.center_x));
    r.point_y = clamp32(best_p[1] + 128'(q.center_y));
    r.point_z = clamp32(best_p[2] + 128'(q.center_z));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = corner_q.size();

  // Track config, queue predictions, compare results
  always @(posedge clk) begin
    out_item_t exp_c;
    if (!rst_n) begin
      ext_x <= HALF_RESET; ext_y <= HALF_RESET; ext_z <= HALF_RESET;
      corner_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HALF_X: ext_x <= cfg_data;
          REG_HALF_Y: ext_y <= cfg_data;
          REG_HALF_Z: ext_z <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) corner_q.push_back(support_corner(in_data));
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (corner_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.point_x, '0);
        end else begin
          exp_c = corner_q.pop_front();
          if (out_data.point_x !== exp_c.point_x)
            report_mismatch("point_x", out_data.point_x, exp_c.point_x);
          if (out_data.point_y !== exp_c.point_y)
            report_mismatch("point_y", out_data.point_y, exp_c.point_y);
          if (out_data.point_z !== exp_c.point_z)
            report_mismatch("point_z", out_data.point_z, exp_c.point_z);
        end
      end
    end
  end
endmodule

>>> tb/tb_obb_support_point.sv
// Testbench top for the oriented-box support point: stimulus, config phases and verdict.
module tb_obb_support_point;
  import obb_sp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t  in_data;
  out_item_t out_data;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  int fail_count, pending, checked;
  int sent;
  bit hold_done;

  obb_support_point uut (.*);

  obb_support_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Runaway guard
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_rot();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (r < 9) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'sh4000 : 16'shc000;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_query();
    in_item_t q;
    q.dir_x = rand_word(); q.dir_y = rand_word(); q.dir_z = rand_word();
    q.center_x = rand_word(); q.center_y = rand_word(); q.center_z = rand_word();
    q.rot_w = rand_rot(); q.rot_x = rand_rot(); q.rot_y = rand_rot(); q.rot_z = rand_rot();
    return q;
  endfunction

  // Send one request, waiting out the stall; valid stays high when no gap follows
  task automatic send_request(input in_item_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Receiver stall, with one long hold-off to fill the pipe
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sent > 300) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1;
      end else if ($urandom_range(0, 9) < 2) begin
        out_stall <= 1'b1;
        repeat (1 + gap_len()) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    in_item_t q;
    logic [30:0] ext_set[5][3];
    in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    sent = 0;
    rst_n = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: zero direction, axes, extremes, non-unit and out-of-range rotations
    q = '0; q.rot_w = 16'sd16384;
    send_request(q);
    for (int a = 0; a < 6; a++) begin
      q = '0; q.rot_w = 16'sd16384;
      case (a % 3)
        0: q.dir_x = (a < 3) ? 32'sh10000 : -32'sh10000;
        1: q.dir_y = (a < 3) ? 32'sh10000 : -32'sh10000;
        default: q.dir_z = (a < 3) ? 32'sh10000 : -32'sh10000;
      endcase
      send_request(q);
    end
    q = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    send_request(q);
    q = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h80000000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    send_request(q);
    q = '{32'h1, 32'h1, 32'h1, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
    send_request(q);
    q = '{32'h10000, 32'h10000, 32'h0, 0, 0, 0, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
    send_request(q);
    q = '{32'h10000, 32'h0, 32'h0, 0, 0, 0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    send_request(q);
    q = '{32'h0, 32'h0, 32'h0, 5, -5, 7, 16'sd8000, 16'sd20000, 16'sd0, 16'sd0};
    send_request(q);
    drain();

    // Config phases: extremes, zero, mixed fixed values, 1.0 and random
    ext_set = '{'{31'h7fffffff, 31'h7fffffff, 31'h7fffffff},
                '{31'd0, 31'd0, 31'd0},
                '{31'd0, 31'h7fffffff, 31'd1},
                '{31'd3 << 16, 31'd1 << 15, 31'd7 << 14},
                '{31'd65536, 31'd65536, 31'd65536}};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_reg(REG_HALF_X, ext_set[ph][0]);
        write_reg(REG_HALF_Y, ext_set[ph][1]);
        write_reg(REG_HALF_Z, ext_set[ph][2]);
      end else begin
        write_reg(REG_HALF_X, 31'($urandom));
        write_reg(REG_HALF_Y, 31'($urandom_range(0, 1 << 22)));
        write_reg(REG_HALF_Z, 31'($urandom));
      end
      for (int n = 0; n < 205; n++) send_request(rand_query());
      drain();
    end

    $display("Sent %0d queries over seven half-extent settings, %0d results checked.",
             sent, checked);
    $display("Included a zero direction, saturating centers and a long output hold-off.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
